FILE: design/ptl_pkg.sv
package ptl_pkg;

  localparam int DEPTH       = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 5;
  localparam int TICKET_W    = 32;
  localparam int ACTION_W    = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  // Compare width: holds fill + 1 and any position without wrapping.
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_TDATA_W  = ((TICKET_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TICKET_W + COUNT_W + 7) / 8) * 8;

  typedef logic signed [TICKET_W-1:0] ticket_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_RM_HEAD = 3'd2,
    ACT_RM_TAIL = 3'd3,
    ACT_RM_POS  = 3'd4,
    ACT_UPDATE  = 3'd5,
    ACT_DISPLAY = 3'd6,
    ACT_NONE    = 3'd7
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_HOLD  = 2'd0,
    CS_LEFT  = 2'd1,
    CS_RIGHT = 2'd2,
    CS_LOAD  = 2'd3
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
  } cell_ctl_t;

endpackage

FILE: design/ptl_cell.sv
module ptl_cell (
  input  logic              clk,
  input  ptl_pkg::cell_ctl_t ctl,
  input  ptl_pkg::ticket_t  left_i,
  input  ptl_pkg::ticket_t  right_i,
  input  ptl_pkg::ticket_t  load_i,
  output ptl_pkg::ticket_t  val_o
);
  import ptl_pkg::*;

  ticket_t val_r;
  ticket_t val_nxt;

  always_comb begin
    case (ctl.sel)
      CS_HOLD:  val_nxt = val_r;
      CS_LEFT:  val_nxt = left_i;
      CS_RIGHT: val_nxt = right_i;
      CS_LOAD:  val_nxt = load_i;
      default:  val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

FILE: design/positional_ticket_list_core.sv
// Ordered ticket list held in a row of cells that shift toward either neighbor.
// Append, insert, remove and update: one result word, ready in the cycle after accept;
// a new word is taken in the cycle the previous result word leaves, so one per cycle
// when the result side never stalls, and none while a result word waits.
// Display: one entry word per cycle unless the result side stalls; the chain rotates once.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared and are never read before being written.
module positional_ticket_list_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] ticket, [36:32] position, [39:37] zero
  input  logic [ptl_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] action
  input  logic [ptl_pkg::ACTION_W-1:0]      in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] entry_value, [36:32] entry_count, [39:37] zero
  output logic [ptl_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [1:0] status
  output logic [ptl_pkg::STATUS_W-1:0]      out_tuser,
  output logic                              out_tlast
);
  import ptl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  ticket_t             out_value_r, out_value_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_load;

  ticket_t             slot [DEPTH];
  ticket_t             right_in [DEPTH];
  ticket_t             left_in [DEPTH];
  cell_ctl_t           ctl [DEPTH];

  action_t             act;
  ticket_t             in_ticket;
  logic [POS_W-1:0]    in_pos;
  logic                out_free, acc, disp_step, disp_last;
  logic [CMP_W-1:0]    fill_x, pos_x, idx_x, fill_m1_x, new_fill_x;
  logic                do_ins, do_rm, do_upd;
  status_t             st;

  assign act       = action_t'(in_tuser);
  assign in_ticket = in_tdata[TICKET_W-1:0];
  assign in_pos    = in_tdata[TICKET_W +: POS_W];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign disp_step = (state_r == S_DISP) && out_free;

  assign fill_x    = CMP_W'(fill_r);
  assign pos_x     = CMP_W'(in_pos);
  assign fill_m1_x = fill_x - CMP_W'(1);
  assign disp_last = (CMP_W'(cnt_r) == fill_m1_x);

  // Decode the action into one edit of the cell row.
  always_comb begin
    st     = ST_OK;
    do_ins = 1'b0;
    do_rm  = 1'b0;
    do_upd = 1'b0;
    idx_x  = '0;
    case (act)
      ACT_APPEND: begin
        if (fill_r >= CNT_W'(DEPTH)) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx_x  = fill_x;
        end
      end
      ACT_INSERT: begin
        if (fill_r >= CNT_W'(DEPTH)) st = ST_FULL;
        else if (in_pos == '0) st = ST_RANGE;
        else begin
          do_ins = 1'b1;
          idx_x  = (pos_x > fill_x + CMP_W'(1)) ? fill_x : pos_x - CMP_W'(1);
        end
      end
      ACT_RM_HEAD: begin
        if (fill_r == '0) st = ST_EMPTY;
        else do_rm = 1'b1;
      end
      ACT_RM_TAIL: begin
        if (fill_r == '0) st = ST_EMPTY;
        else begin
          do_rm = 1'b1;
          idx_x = fill_m1_x;
        end
      end
      ACT_RM_POS, ACT_UPDATE: begin
        if (fill_r == '0) st = ST_EMPTY;
        else if (in_pos == '0 || pos_x > fill_x) st = ST_RANGE;
        else begin
          idx_x  = pos_x - CMP_W'(1);
          do_rm  = (act == ACT_RM_POS);
          do_upd = (act == ACT_UPDATE);
        end
      end
      default: ;
    endcase
  end

  // Per-cell selects. During display the occupied cells rotate toward the
  // head, so the head cell always holds the next entry to send.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].sel = CS_HOLD;
      if (disp_step) begin
        if (CMP_W'(i) < fill_x) ctl[i].sel = CS_RIGHT;
      end else if (acc && do_ins) begin
        if (CMP_W'(i) == idx_x) ctl[i].sel = CS_LOAD;
        else if (CMP_W'(i) > idx_x && CMP_W'(i) <= fill_x) ctl[i].sel = CS_LEFT;
      end else if (acc && do_upd) begin
        if (CMP_W'(i) == idx_x) ctl[i].sel = CS_LOAD;
      end else if (acc && do_rm) begin
        if (CMP_W'(i) >= idx_x && CMP_W'(i) < fill_m1_x) ctl[i].sel = CS_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = slot[g];
    end else begin : g_body
      assign left_in[g] = slot[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_in[g] = slot[0];
    end else begin : g_mid
      assign right_in[g] = (CMP_W'(g) == fill_m1_x) ? slot[0] : slot[g+1];
    end

    ptl_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .left_i  (left_in[g]),
      .right_i (right_in[g]),
      .load_i  (in_ticket),
      .val_o   (slot[g])
    );
  end

  always_comb begin
    new_fill_x = fill_x;
    if (do_ins) new_fill_x = fill_x + CMP_W'(1);
    else if (do_rm) new_fill_x = fill_m1_x;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (disp_step) begin
      out_load       = 1'b1;
      out_status_nxt = ST_OK;
      out_value_nxt  = slot[0];
      out_count_nxt  = fill_x[COUNT_W-1:0];
      out_last_nxt   = disp_last;
      cnt_nxt        = cnt_r + CNT_W'(1);
      if (disp_last) state_nxt = S_IDLE;
    end else if (acc) begin
      if (act == ACT_DISPLAY && fill_r != '0) begin
        state_nxt = S_DISP;
        cnt_nxt   = '0;
      end else begin
        out_load       = 1'b1;
        out_status_nxt = (act == ACT_DISPLAY) ? ST_EMPTY : st;
        out_value_nxt  = '0;
        out_count_nxt  = new_fill_x[COUNT_W-1:0];
        out_last_nxt   = 1'b1;
        fill_nxt       = new_fill_x[CNT_W-1:0];
      end
    end
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - TICKET_W - COUNT_W){1'b0}}, out_count_r, out_value_r};

  // The list never holds more than its capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  // A full status is only reported while the list is at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> (fill_r == CNT_W'(DEPTH)))
    else $error("full status with free room");

  // Display never changes the number of entries.
  a_disp_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |=> (fill_r == $past(fill_r)))
    else $error("fill changed during display");

  // No new word is taken while a display is streaming.
  a_disp_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |-> !in_tready)
    else $error("input accepted during display");

endmodule
